FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the haptic pattern arbiter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hpa_pkg.sv
// Package with the types, codes and widths of the haptic pattern arbiter.
`timescale 1ns / 1ps
package hpa_pkg;

  localparam int PERIOD_W = 16;
  localparam int TIMER_W  = 48;

  localparam int FIELD_W = 16;
  localparam int EFF_W   = FIELD_W + 2;
  localparam int DVS_W   = FIELD_W + 1;
  localparam int MSK_W   = 10;
  localparam int DVD_W   = FIELD_W + MSK_W;
  localparam int REP_W   = 31;
  localparam int PRIO_W  = 9;
  localparam int PROD_W  = EFF_W + REP_W;
  localparam int WIDE_W  = (TIMER_W > PROD_W) ? TIMER_W : PROD_W;
  localparam int DIVC_W  = $clog2(DVD_W);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [FIELD_W-1:0] PERIOD_MASK =
    FIELD_W'((65'(1) << PERIOD_W) - 65'(1));
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [PRIO_W-1:0]  IDLE_PRIO = PRIO_W'(256);
  localparam logic [REP_W-1:0]   FOREVER   = '1;
  localparam logic [MSK_W-1:0]   MS_PER_S  = MSK_W'(1000);

  localparam logic [3:0] KIND_PLAY     = 4'd0;
  localparam logic [3:0] KIND_STOP     = 4'd1;
  localparam logic [3:0] KIND_ARM      = 4'd2;
  localparam logic [3:0] KIND_DISARM   = 4'd3;
  localparam logic [3:0] KIND_MSTART   = 4'd4;
  localparam logic [3:0] KIND_MSTOP    = 4'd5;
  localparam logic [3:0] KIND_OUTSTOP  = 4'd6;
  localparam logic [3:0] KIND_DISPLAY  = 4'd7;
  localparam logic [3:0] KIND_SYSTEM   = 4'd8;
  localparam logic [3:0] KIND_TICK     = 4'd9;

  localparam logic [2:0] POL_OFF_NORMAL  = 3'd0;
  localparam logic [2:0] POL_ON_NORMAL   = 3'd1;
  localparam logic [2:0] POL_OFF_ACTDEAD = 3'd2;
  localparam logic [2:0] POL_ALWAYS      = 3'd3;
  localparam logic [2:0] POL_OFF_OR_AD   = 3'd4;
  localparam logic [2:0] POL_ALWAYS_ALT  = 3'd5;

  localparam logic [1:0] DISP_OFF = 2'd0;
  localparam logic [1:0] DISP_ON  = 2'd1;
  localparam logic [1:0] SYS_ACT_DEAD = 2'd1;

  typedef enum logic [3:0] {
    OP_PLAY, OP_STOP, OP_ARM, OP_DISARM, OP_MSTART,
    OP_OUTSTOP, OP_DISPLAY, OP_SYSTEM, OP_TICK, OP_NONE
  } hpa_op_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_STOP = 2'd2
  } hpa_act_t;

  typedef enum logic [2:0] {
    B_IDLE, B_EXEC, B_DIV, B_MUL, B_EMIT
  } hpa_bstate_t;

  typedef struct packed {
    hpa_op_t              op;
    logic                 pat_valid;
    logic [7:0]           prio;
    logic [2:0]           policy;
    logic [FIELD_W-1:0]   timeout_s;
    logic [REP_W-1:0]     rep_cnt;
    logic [FIELD_W-1:0]   accel_ms;
    logic [FIELD_W-1:0]   on_ms;
    logic [FIELD_W-1:0]   decel_ms;
    logic [FIELD_W-1:0]   off_ms;
    logic [7:0]           speed;
    logic [1:0]           state_val;
    logic [EFF_W-1:0]     effect_ms;
    logic [DVS_W-1:0]     divisor;
  } hpa_cmd_t;

  typedef struct packed {
    hpa_act_t             action;
    logic [EFF_W-1:0]     effect_ms;
    logic [FIELD_W-1:0]   gap_ms;
    logic [REP_W-1:0]     repeats;
    logic [7:0]           drive_speed;
    logic [FIELD_W-1:0]   attack_ms;
    logic [FIELD_W-1:0]   fade_ms;
    logic [PRIO_W-1:0]    active_prio;
  } hpa_res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hpa_qstat_t;

endpackage

FILE: rtl/core/haptic_pattern_arbiter.sv
// Top level of the haptic pattern arbiter: stream ports, front end, queue and back end.
`timescale 1ns / 1ps
// Usage: each input transfer carries one request or state event (kind in in_tuser) and
// yields exactly one result transfer, in order, on the out_ channel. The result's
// out_tuser holds the action (nothing, run effect, stop effect), and out_tdata holds the
// effect parameters and the held priority after the request.
// The front end decodes a transfer into a four-entry queue; in_tready is low only while
// that queue is full. The back end works on one queued command at a time:
// most requests pass from the queue head through the idle, execute and emit states
// to the output register; a play with an explicit or unlimited repeat count also passes
// the multiply state, and a play whose repeat count comes from its timeout first passes
// the one-bit-per-cycle restoring divider (26 steps) and then the multiply state.
// The back end takes the next queued command only after emitting the last result.
// The output register holds a result until out_tready; while the receiver stalls the
// queue keeps taking input until it fills, then in_tready falls.
// Reset (rst_n low at a clock edge) empties the queue and output register, sets the held
// priority to idle (256), arms the motor, selects display off and not act-dead, and
// stops and clears the hold timer.
module haptic_pattern_arbiter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pattern_valid, request_priority, play_policy, timeout_s, rep_cnt, accel_ms,
  // on_ms, decel_ms, off_ms, motor_speed, state_value
  input  logic [135:0] in_tdata,
  // kind
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // effect_ms, gap_ms, repeats, drive_speed, attack_ms, fade_ms, active_priority
  output logic [119:0] out_tdata,
  // action
  output logic [1:0]   out_tuser
);
  import hpa_pkg::*;

  hpa_cmd_t   front_cmd;
  hpa_cmd_t   head_cmd;
  hpa_qstat_t qstat;
  hpa_res_t   res;
  logic       push;
  logic       pop;

  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready;

  hpa_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd      (front_cmd)
  );

  hpa_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .head   (head_cmd),
    .stat   (qstat)
  );

  hpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.action;
  assign out_tdata = {6'b0, res.active_prio, res.fade_ms, res.attack_ms,
                      res.drive_speed, res.repeats, res.gap_ms, res.effect_ms};

endmodule

FILE: rtl/core/hpa_front.sv
// Front end: unpacks an input transfer and classifies it into a command.
`timescale 1ns / 1ps
module hpa_front (
  input  logic [135:0]      in_tdata,
  input  logic [3:0]        in_tuser,
  output hpa_pkg::hpa_cmd_t cmd
);
  import hpa_pkg::*;

  logic [FIELD_W-1:0] acc;
  logic [FIELD_W-1:0] onp;
  logic [FIELD_W-1:0] dec;
  logic [FIELD_W-1:0] offp;

  assign acc  = in_tdata[74:59]   & PERIOD_MASK;
  assign onp  = in_tdata[90:75]   & PERIOD_MASK;
  assign dec  = in_tdata[106:91]  & PERIOD_MASK;
  assign offp = in_tdata[122:107] & PERIOD_MASK;

  always_comb begin
    cmd.pat_valid    = in_tdata[0];
    cmd.prio         = in_tdata[8:1];
    cmd.policy       = in_tdata[11:9];
    cmd.timeout_s    = in_tdata[27:12];
    cmd.rep_cnt      = in_tdata[58:28];
    cmd.accel_ms     = acc;
    cmd.on_ms        = onp;
    cmd.decel_ms     = dec;
    cmd.off_ms       = offp;
    cmd.speed        = in_tdata[130:123];
    cmd.state_val    = in_tdata[132:131];
    cmd.effect_ms    = EFF_W'(acc) + EFF_W'(onp) + EFF_W'(dec);
    cmd.divisor      = DVS_W'(onp) + DVS_W'(offp);
    unique case (in_tuser) inside
      KIND_PLAY:              cmd.op = OP_PLAY;
      KIND_STOP, KIND_MSTOP:  cmd.op = OP_STOP;
      KIND_ARM:               cmd.op = OP_ARM;
      KIND_DISARM:            cmd.op = OP_DISARM;
      KIND_MSTART:            cmd.op = OP_MSTART;
      KIND_OUTSTOP:           cmd.op = OP_OUTSTOP;
      KIND_DISPLAY:           cmd.op = OP_DISPLAY;
      KIND_SYSTEM:            cmd.op = OP_SYSTEM;
      KIND_TICK:              cmd.op = OP_TICK;
      default:                cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/hpa_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hpa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hpa_pkg::hpa_cmd_t   wr_cmd,
  input  logic                pop,
  output hpa_pkg::hpa_cmd_t   head,
  output hpa_pkg::hpa_qstat_t stat
);
  import hpa_pkg::*;

  hpa_cmd_t            slot_r [QDEPTH];
  logic [QPTR_W:0]     wr_ptr_r;
  logic [QPTR_W:0]     wr_ptr_nxt;
  logic [QPTR_W:0]     rd_ptr_r;
  logic [QPTR_W:0]     rd_ptr_nxt;

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;

  assign stat.empty = (wr_ptr_r == rd_ptr_r);
  assign stat.full  = (wr_ptr_r[QPTR_W] != rd_ptr_r[QPTR_W]) &&
                      (wr_ptr_r[QPTR_W-1:0] == rd_ptr_r[QPTR_W-1:0]);
  assign head = slot_r[rd_ptr_r[QPTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r[QPTR_W-1:0]] <= wr_cmd;
    end
  end

  `HPA_ASSERT_NOW(a_q_no_overflow, push, !stat.full, "Queue written while full.")
  `HPA_ASSERT_NOW(a_q_no_underflow, pop, !stat.empty, "Queue read while empty.")

endmodule

FILE: rtl/core/hpa_back.sv
// Back end: arbitration state, repeat-count divider, hold timer and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hpa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hpa_pkg::hpa_cmd_t   head,
  input  hpa_pkg::hpa_qstat_t qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output hpa_pkg::hpa_res_t   out_res
);
  import hpa_pkg::*;

  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(DVD_W - 1);

  hpa_bstate_t         state_r, state_nxt;
  hpa_cmd_t            cur_r, cur_nxt;
  logic [PRIO_W-1:0]   held_prio_r, held_prio_nxt;
  logic                armed_r, armed_nxt;
  logic [1:0]          disp_r, disp_nxt;
  logic                act_dead_r, act_dead_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt;
  logic                tmr_run_r, tmr_run_nxt;
  logic [REP_W-1:0]    cnt_r, cnt_nxt;
  logic [DVD_W-1:0]    dq_r, dq_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVC_W-1:0]   divc_r, divc_nxt;
  hpa_res_t            res_r, res_nxt;
  hpa_res_t            out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                policy_ok;
  logic                play_ok;
  logic                need_div;
  logic                out_free;
  logic [DVS_W:0]      trial;
  logic [DVS_W:0]      diff;
  logic                qbit;
  logic [DVD_W-1:0]    quot;
  logic [REP_W:0]      cnt_sum;
  logic [PROD_W-1:0]   prod;
  logic [WIDE_W-1:0]   prod_wide;

  always_comb begin
    unique case (cur_r.policy) inside
      POL_OFF_NORMAL:             policy_ok = !act_dead_r && (disp_r == DISP_OFF);
      POL_ON_NORMAL:              policy_ok = !act_dead_r && (disp_r == DISP_ON);
      POL_OFF_ACTDEAD:            policy_ok = act_dead_r && (disp_r == DISP_OFF);
      POL_ALWAYS, POL_ALWAYS_ALT: policy_ok = 1'b1;
      POL_OFF_OR_AD:              policy_ok = act_dead_r || (disp_r == DISP_OFF);
      default:                    policy_ok = 1'b0;
    endcase
  end

  assign play_ok  = cur_r.pat_valid && armed_r && policy_ok &&
                    (PRIO_W'(cur_r.prio) < held_prio_r);
  assign need_div = (cur_r.rep_cnt == '0) && (cur_r.timeout_s != '0) &&
                    (cur_r.divisor != '0);
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == B_IDLE) && !qstat.empty;

  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign diff  = trial - {1'b0, cur_r.divisor};
  assign qbit  = !diff[DVS_W];
  assign quot  = {dq_r[DVD_W-2:0], qbit};
  assign cnt_sum = (REP_W + 1)'(quot) + (REP_W + 1)'(1);

  assign prod      = PROD_W'(cur_r.effect_ms) * PROD_W'(cnt_r);
  assign prod_wide = WIDE_W'(prod);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cur_r.op == OP_PLAY && play_ok) begin
          state_nxt = need_div ? B_DIV : B_MUL;
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_DIV: begin
        if (divc_r == DIV_LAST) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    held_prio_nxt = held_prio_r;
    armed_nxt     = armed_r;
    disp_nxt      = disp_r;
    act_dead_nxt  = act_dead_r;
    timer_nxt     = timer_r;
    tmr_run_nxt   = tmr_run_r;
    cnt_nxt       = cnt_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    divc_nxt      = divc_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          cur_nxt = head;
        end
      end
      B_EXEC: begin
        res_nxt        = '0;
        res_nxt.action = ACT_NONE;
        unique case (cur_r.op) inside
          OP_PLAY: begin
            if (play_ok) begin
              held_prio_nxt = PRIO_W'(cur_r.prio);
              dq_nxt        = DVD_W'(cur_r.timeout_s) * DVD_W'(MS_PER_S);
              rem_nxt       = '0;
              divc_nxt      = '0;
              if (cur_r.rep_cnt != '0) begin
                cnt_nxt = cur_r.rep_cnt;
              end else begin
                cnt_nxt = FOREVER;
              end
            end
          end
          OP_STOP, OP_DISARM: begin
            tmr_run_nxt    = 1'b0;
            timer_nxt      = '0;
            held_prio_nxt  = IDLE_PRIO;
            res_nxt.action = ACT_STOP;
            if (cur_r.op == OP_DISARM) begin
              armed_nxt = 1'b0;
            end
          end
          OP_ARM: begin
            armed_nxt = 1'b1;
          end
          OP_MSTART: begin
            if (held_prio_r == IDLE_PRIO) begin
              timer_nxt           = TIMER_W'(cur_r.on_ms);
              tmr_run_nxt         = 1'b1;
              res_nxt.action      = ACT_RUN;
              res_nxt.effect_ms   = EFF_W'(cur_r.on_ms);
              res_nxt.repeats     = REP_W'(1);
              res_nxt.drive_speed = cur_r.speed;
            end
          end
          OP_OUTSTOP: begin
            res_nxt.action = ACT_STOP;
          end
          OP_DISPLAY: begin
            disp_nxt = cur_r.state_val;
          end
          OP_SYSTEM: begin
            act_dead_nxt = (cur_r.state_val == SYS_ACT_DEAD);
          end
          OP_TICK: begin
            if (tmr_run_r) begin
              if (timer_r <= TIMER_W'(1)) begin
                timer_nxt     = '0;
                tmr_run_nxt   = 1'b0;
                held_prio_nxt = IDLE_PRIO;
              end else begin
                timer_nxt = timer_r - 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        res_nxt.active_prio = held_prio_nxt;
      end
      B_DIV: begin
        rem_nxt  = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dq_nxt   = quot;
        divc_nxt = divc_r + 1'b1;
        if (divc_r == DIV_LAST) begin
          cnt_nxt = (cnt_sum > (REP_W + 1)'(FOREVER)) ? FOREVER : cnt_sum[REP_W-1:0];
        end
      end
      B_MUL: begin
        if (cnt_r == FOREVER) begin
          tmr_run_nxt = 1'b0;
          timer_nxt   = '0;
        end else begin
          tmr_run_nxt = 1'b1;
          if (prod_wide > WIDE_W'(TIMER_MAX)) begin
            timer_nxt = TIMER_MAX;
          end else begin
            timer_nxt = prod_wide[TIMER_W-1:0];
          end
        end
        res_nxt.action      = ACT_RUN;
        res_nxt.effect_ms   = cur_r.effect_ms;
        res_nxt.gap_ms      = cur_r.off_ms;
        res_nxt.repeats     = cnt_r;
        res_nxt.drive_speed = cur_r.speed;
        res_nxt.attack_ms   = cur_r.accel_ms;
        res_nxt.fade_ms     = cur_r.decel_ms;
        res_nxt.active_prio = held_prio_r;
      end
      B_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      held_prio_r <= IDLE_PRIO;
      armed_r     <= 1'b1;
      disp_r      <= DISP_OFF;
      act_dead_r  <= 1'b0;
      timer_r     <= '0;
      tmr_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
      divc_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      held_prio_r <= held_prio_nxt;
      armed_r     <= armed_nxt;
      disp_r      <= disp_nxt;
      act_dead_r  <= act_dead_nxt;
      timer_r     <= timer_nxt;
      tmr_run_r   <= tmr_run_nxt;
      out_valid_r <= out_valid_nxt;
      divc_r      <= divc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    cnt_r <= cnt_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `HPA_ASSERT_NOW(a_idle_timer_clear, !tmr_run_r, timer_r == '0,
                  "Hold timer holds a count while stopped.")
  `HPA_ASSERT_NOW(a_prio_range, 1'b1, held_prio_r <= IDLE_PRIO,
                  "Held priority beyond the idle level.")
  `HPA_ASSERT_NOW(a_div_nonzero, state_r == B_DIV, cur_r.divisor != '0,
                  "Repeat-count division started with a zero divisor.")

endmodule
